@@ hw/rtl/srdf_pkg.sv @@
// Shared types, constants and character helpers for the radix display formatter.
`default_nettype none
package srdf_pkg;

  // Widths of the data path
  localparam int NUM_W   = 32;  // input word
  localparam int BASE_W  = 6;   // number base, 2..36
  localparam int MAG_W   = 21;  // in-range magnitude, below 36^4
  localparam int CHAR_W  = 7;   // ASCII code
  localparam int NPOS    = 4;   // display positions
  localparam int DIG_W   = 6;   // one digit, below 36

  // Number base limits
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Back pipeline: one quotient bit per stage for digits 3, 2 and 1
  localparam int N_STG = (NPOS - 1) * DIG_W;

  // Settle count loaded by a configuration write while the power registers refresh
  localparam int SETTLE_CYC = 4;
  localparam int SETTLE_W   = 3;

  // Configuration register indexes
  localparam logic CFG_RADIX = 1'b0;
  localparam logic CFG_PAD   = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [0:NPOS-1][CHAR_W-1:0] TXT_HIGH = {7'h48, 7'h49, 7'h47, 7'h48};
  localparam logic [0:NPOS-1][CHAR_W-1:0] TXT_LOW  = {7'h4C, 7'h4F, 7'h57, 7'h20};

  // Range status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HIGH = 2'd1,
    ST_LOW  = 2'd2
  } status_t;

  // Powers of the base, refreshed from the radix register
  typedef struct packed {
    logic [BASE_W-1:0] b;
    logic [11:0]       b2;
    logic [15:0]       b3;
    logic [MAG_W-1:0]  b4;
  } pow_t;

  // Classified word passed from front to back
  typedef struct packed {
    status_t          status;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } word_t;

  // Digit value to ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d <= 6'd9) begin
      digit_char = CH_ZERO + dx;
    end else begin
      digit_char = CH_A + dx - 7'd10;
    end
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/srdf_front.sv @@
// Front end: accepts input words, takes the magnitude and classifies the range.
`default_nettype none
module srdf_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [srdf_pkg::NUM_W-1:0] in_number,
  input  wire logic                              block,
  input  wire srdf_pkg::pow_t                    pow,
  input  wire logic                              q_full,
  output logic                                   push,
  output srdf_pkg::word_t                        word
);

  logic                         f_valid_r;
  srdf_pkg::word_t              f_word_r;
  srdf_pkg::word_t              f_word_nxt;
  logic                         f_ready;
  logic                         accept;
  logic                         neg;
  logic [srdf_pkg::NUM_W-1:0]   mag;

  // Hand the held word on whenever the queue has room
  assign push     = f_valid_r && !q_full;
  assign f_ready  = !f_valid_r || !q_full;
  assign in_stall = !f_ready || block;
  assign accept   = in_valid && !in_stall;
  assign word     = f_word_r;

  // Take the magnitude and compare against the range limits
  always_comb begin
    neg = in_number[srdf_pkg::NUM_W-1];
    mag = neg ? (~in_number + 32'd1) : in_number;
    f_word_nxt.neg = neg;
    f_word_nxt.mag = mag[srdf_pkg::MAG_W-1:0];
    if (!neg && (mag >= {{(srdf_pkg::NUM_W-srdf_pkg::MAG_W){1'b0}}, pow.b4})) begin
      f_word_nxt.status = srdf_pkg::ST_HIGH;
    end else if (neg && (mag >= {16'd0, pow.b3})) begin
      f_word_nxt.status = srdf_pkg::ST_LOW;
    end else begin
      f_word_nxt.status = srdf_pkg::ST_OK;
    end
  end

  // Hold the classified word until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (f_ready) begin
      f_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_word_r <= f_word_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/srdf_queue.sv @@
// Short queue of classified words between the front and back ends.
`default_nettype none
module srdf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire srdf_pkg::word_t wr_word,
  input  wire logic            pop,
  output srdf_pkg::word_t      rd_word,
  output logic                 empty,
  output logic                 full
);

  srdf_pkg::word_t               mem_r [srdf_pkg::Q_DEPTH];
  logic [srdf_pkg::Q_PTR_W-1:0]  wr_ptr_r;
  logic [srdf_pkg::Q_PTR_W-1:0]  rd_ptr_r;
  logic [srdf_pkg::Q_CNT_W-1:0]  cnt_r;
  logic                          do_push;
  logic                          do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == srdf_pkg::Q_CNT_W'(srdf_pkg::Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_word = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/srdf_back.sv @@
// Back end: digit extraction pipeline, character formatting and output register.
`default_nettype none
module srdf_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire srdf_pkg::word_t              q_word,
  input  wire logic                         q_empty,
  output logic                              pop,
  input  wire srdf_pkg::pow_t               pow,
  input  wire logic                         pad,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [srdf_pkg::CHAR_W-1:0]       out_char_left,
  output logic [srdf_pkg::CHAR_W-1:0]       out_char_second,
  output logic [srdf_pkg::CHAR_W-1:0]       out_char_third,
  output logic [srdf_pkg::CHAR_W-1:0]       out_char_right,
  output logic [1:0]                        out_range_status
);

  localparam int NS = srdf_pkg::N_STG;
  localparam int MW = srdf_pkg::MAG_W;
  localparam int DW = srdf_pkg::DIG_W;

  typedef struct packed {
    srdf_pkg::status_t           status;
    logic                        neg;
    logic [MW-1:0]               rem;
    logic [3:1][DW-1:0]          dig;
  } stage_t;

  stage_t                       st_r [NS];
  logic [NS-1:0]                vld_r;
  logic                         en;

  logic                         out_valid_r;
  logic [srdf_pkg::CHAR_W-1:0]  ch_left_r;
  logic [srdf_pkg::CHAR_W-1:0]  ch_second_r;
  logic [srdf_pkg::CHAR_W-1:0]  ch_third_r;
  logic [srdf_pkg::CHAR_W-1:0]  ch_right_r;
  logic [1:0]                   status_r;

  logic [0:srdf_pkg::NPOS-1][srdf_pkg::CHAR_W-1:0] ch_nxt;
  logic [srdf_pkg::NPOS-1:0][DW-1:0]               dig_all;
  logic [srdf_pkg::NPOS-1:0]                       sig;

  // Advance the whole pipeline whenever the output slot frees up
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && !q_empty;

  // One restoring division step per stage, most significant digit first
  for (genvar s = 0; s < NS; s++) begin : g_stg
    localparam int K = 3 - s / DW;
    localparam int J = (DW - 1) - s % DW;

    stage_t            src;
    logic              src_v;
    stage_t            nxt;
    logic [MW:0]       pk;
    logic [MW:0]       dvs;

    if (s == 0) begin : g_head
      always_comb begin
        src.status = q_word.status;
        src.neg    = q_word.neg;
        src.rem    = q_word.mag;
        src.dig    = '0;
        src_v      = !q_empty;
      end
    end else begin : g_link
      always_comb begin
        src   = st_r[s-1];
        src_v = vld_r[s-1];
      end
    end

    if (K == 3) begin : g_p3
      assign pk = (MW + 1)'(pow.b3);
    end else if (K == 2) begin : g_p2
      assign pk = (MW + 1)'(pow.b2);
    end else begin : g_p1
      assign pk = (MW + 1)'(pow.b);
    end

    always_comb begin
      dvs = pk << J;
      nxt = src;
      if ({1'b0, src.rem} >= dvs) begin
        nxt.rem       = src.rem - dvs[MW-1:0];
        nxt.dig[K][J] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[s] <= nxt;
      end
    end
  end

  // Format the four positions from the finished digits
  always_comb begin
    dig_all[0] = st_r[NS-1].rem[DW-1:0];
    dig_all[1] = st_r[NS-1].dig[1];
    dig_all[2] = st_r[NS-1].dig[2];
    dig_all[3] = st_r[NS-1].dig[3];
    // A position is significant when it or any higher digit is nonzero
    sig[srdf_pkg::NPOS-1] = (dig_all[srdf_pkg::NPOS-1] != '0);
    for (int r = srdf_pkg::NPOS - 2; r >= 0; r--) begin
      sig[r] = sig[r+1] || (dig_all[r] != '0);
    end
    for (int r = 0; r < srdf_pkg::NPOS; r++) begin
      case (st_r[NS-1].status)
        srdf_pkg::ST_HIGH: ch_nxt[3-r] = srdf_pkg::TXT_HIGH[3-r];
        srdf_pkg::ST_LOW:  ch_nxt[3-r] = srdf_pkg::TXT_LOW[3-r];
        srdf_pkg::ST_OK: begin
          if (st_r[NS-1].neg) begin
            // Digits, then one minus sign right above the top digit
            if (sig[r]) begin
              ch_nxt[3-r] = srdf_pkg::digit_char(dig_all[r]);
            end else if (r == 0 || sig[(r == 0) ? 0 : r - 1]) begin
              ch_nxt[3-r] = srdf_pkg::CH_MINUS;
            end else begin
              ch_nxt[3-r] = srdf_pkg::CH_SPACE;
            end
          end else begin
            // Rightmost digit always shows; pad the rest as configured
            if (sig[r] || r == 0) begin
              ch_nxt[3-r] = srdf_pkg::digit_char(dig_all[r]);
            end else if (pad) begin
              ch_nxt[3-r] = srdf_pkg::CH_ZERO;
            end else begin
              ch_nxt[3-r] = srdf_pkg::CH_SPACE;
            end
          end
        end
        default: ch_nxt[3-r] = srdf_pkg::CH_SPACE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_left_r   <= ch_nxt[0];
      ch_second_r <= ch_nxt[1];
      ch_third_r  <= ch_nxt[2];
      ch_right_r  <= ch_nxt[3];
      status_r    <= st_r[NS-1].status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_left    = ch_left_r;
  assign out_char_second  = ch_second_r;
  assign out_char_third   = ch_third_r;
  assign out_char_right   = ch_right_r;
  assign out_range_status = status_r;

endmodule
`default_nettype wire

@@ hw/rtl/signed_radix_display_formatter_unit.sv @@
// Top level: configuration registers, base powers, front end, queue and back end.
// Throughput: one word per cycle unless the output stalls or a configuration write holds
// off input; an input word passes the front register and a four-word queue into the back
// end, an 18-stage digit pipeline with one quotient bit per stage, then the output register.
// After a configuration write the input stalls while the base powers refresh.
// Reset (synchronous, rst_n low) empties the pipeline and queue and sets base 10, space pad.
`default_nettype none
module signed_radix_display_formatter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [srdf_pkg::NUM_W-1:0] in_number,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [srdf_pkg::CHAR_W-1:0]            out_char_left,
  output logic [srdf_pkg::CHAR_W-1:0]            out_char_second,
  output logic [srdf_pkg::CHAR_W-1:0]            out_char_third,
  output logic [srdf_pkg::CHAR_W-1:0]            out_char_right,
  output logic [1:0]                             out_range_status,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [srdf_pkg::BASE_W-1:0]       cfg_data
);

  logic [srdf_pkg::BASE_W-1:0]   radix_r;
  logic                          pad_r;
  logic [srdf_pkg::BASE_W-1:0]   base_nxt;
  srdf_pkg::pow_t                pow_r;
  logic [11:0]                   b2_nxt;
  logic [17:0]                   b3_prod;
  logic [21:0]                   b4_prod;
  logic [srdf_pkg::SETTLE_W-1:0] settle_r;
  logic                          block;

  logic                          push;
  srdf_pkg::word_t               f_word;
  logic                          q_full;
  logic                          q_empty;
  logic                          pop;
  srdf_pkg::word_t               q_word;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= srdf_pkg::BASE_RESET;
      pad_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        srdf_pkg::CFG_RADIX: radix_r <= cfg_data;
        srdf_pkg::CFG_PAD:   pad_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the base and build its powers, one multiply per register
  always_comb begin
    if (radix_r < srdf_pkg::BASE_MIN) begin
      base_nxt = srdf_pkg::BASE_MIN;
    end else if (radix_r > srdf_pkg::BASE_MAX) begin
      base_nxt = srdf_pkg::BASE_MAX;
    end else begin
      base_nxt = radix_r;
    end
    b2_nxt  = {6'd0, pow_r.b} * {6'd0, pow_r.b};
    b3_prod = {6'd0, pow_r.b2} * {12'd0, pow_r.b};
    b4_prod = {6'd0, pow_r.b3} * {16'd0, pow_r.b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow_r.b  <= 6'd10;
      pow_r.b2 <= 12'd100;
      pow_r.b3 <= 16'd1000;
      pow_r.b4 <= 21'd10000;
    end else begin
      pow_r.b  <= base_nxt;
      pow_r.b2 <= b2_nxt;
      pow_r.b3 <= b3_prod[15:0];
      pow_r.b4 <= b4_prod[srdf_pkg::MAG_W-1:0];
    end
  end

  // Hold off input until the powers have caught up with a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= '0;
    end else if (cfg_we) begin
      settle_r <= srdf_pkg::SETTLE_W'(srdf_pkg::SETTLE_CYC);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  assign block = cfg_we || (settle_r != '0);

  srdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_number (in_number),
    .block     (block),
    .pow       (pow_r),
    .q_full    (q_full),
    .push      (push),
    .word      (f_word)
  );

  srdf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_word (f_word),
    .pop     (pop),
    .rd_word (q_word),
    .empty   (q_empty),
    .full    (q_full)
  );

  srdf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_word           (q_word),
    .q_empty          (q_empty),
    .pop              (pop),
    .pow              (pow_r),
    .pad              (pad_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_left    (out_char_left),
    .out_char_second  (out_char_second),
    .out_char_third   (out_char_third),
    .out_char_right   (out_char_right),
    .out_range_status (out_range_status)
  );

`ifndef NO_ASSERTIONS
  // Queue can never report full and empty together
  a_q_flags: assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
    else $error("queue full and empty at once");

  // No word may enter right after a configuration write
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n) cfg_we |=> in_stall)
    else $error("input accepted while base powers refresh");

  // Status code is always one of the three defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_range_status != 2'd3))
    else $error("undefined range status");

  // A stalled result stays valid until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire
